### rtl/core/hyp_pkg.sv
// ----------------------------------------------------------------------------
// hyp_pkg: shared types and constants for the integer hypotenuse pipeline
// Field widths, pipeline partitioning and the square root step function.
// ----------------------------------------------------------------------------
package hyp_pkg;

    localparam int DATA_W          = 32;
    localparam int MAG_W           = 15;
    localparam int SHIFT_W         = 5;
    localparam int LEN_W           = 6;
    localparam int ROOT_STEPS      = 16;
    localparam int STEPS_PER_STAGE = 2;
    localparam int ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;

    localparam logic [DATA_W-1:0] ROOT_START = 32'h4000_0000;

    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
        logic [SHIFT_W-1:0] shift;
    } scaled_t;

    typedef struct packed {
        logic [DATA_W-1:0]  rem;
        logic [DATA_W-1:0]  root;
        logic [SHIFT_W-1:0] shift;
    } root_t;

    // one restoring step; step k tests bit 2^(30-2k)
    function automatic root_t root_step(input root_t cur, input int k);
        logic [DATA_W-1:0] bit_v;
        logic [DATA_W-1:0] trial;
        root_t             nxt;
        bit_v = ROOT_START >> (2 * k);
        trial = cur.root + bit_v;
        nxt   = cur;
        nxt.root = cur.root >> 1;
        if (trial <= cur.rem) begin
            nxt.rem  = cur.rem - trial;
            nxt.root = (cur.root >> 1) + bit_v;
        end
        return nxt;
    endfunction

endpackage

### rtl/core/integer_hypotenuse.sv
// ----------------------------------------------------------------------------
// integer_hypotenuse: rounded integer length of a 2-D vector
// Stream in two signed deltas, stream out the rounded length.
// ----------------------------------------------------------------------------
// The block accepts one vector per clock cycle while the output side does not
// stall. Each length passes through two stages for magnitude and prescale,
// two for the squares and their sum, eight for the sixteen square root
// steps and two for rounding and the shift back. Every stage has its own
// valid bit and a stage may load whenever it is empty or its successor
// moves, so bubbles close up under back-pressure and no transaction is
// dropped or repeated. Results leave in input order and wrap modulo 2^32
// for very large inputs.
module integer_hypotenuse (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] delta_x, [63:32] delta_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] distance
);

    logic             pre_valid, pre_ready;
    hyp_pkg::scaled_t pre_data;
    logic             sq_valid, sq_ready;
    hyp_pkg::root_t   sq_data;
    logic             root_valid, root_ready;
    hyp_pkg::root_t   root_data;

    hyp_prescale u_prescale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .delta_x   (s_tdata[31:0]),
        .delta_y   (s_tdata[63:32]),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_data  (pre_data)
    );

    hyp_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_data   (pre_data),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    hyp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    hyp_rescale u_rescale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (root_valid),
        .in_ready  (root_ready),
        .in_data   (root_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .distance  (m_tdata)
    );

endmodule

### rtl/core/hyp_prescale.sv
// ----------------------------------------------------------------------------
// hyp_prescale: magnitude and prescale stages
// Takes absolute values, finds the common right shift that brings both
// magnitudes below 2^15, then applies it.
// ----------------------------------------------------------------------------
module hyp_prescale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hyp_pkg::DATA_W-1:0]   delta_x,
    input  logic [hyp_pkg::DATA_W-1:0]   delta_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hyp_pkg::scaled_t             out_data
);

    logic [hyp_pkg::DATA_W-1:0]  mag_x_reg, mag_x_next;
    logic [hyp_pkg::DATA_W-1:0]  mag_y_reg, mag_y_next;
    logic [hyp_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                        valid1_reg;
    hyp_pkg::scaled_t            scaled_reg, scaled_next;
    logic                        valid2_reg;
    logic                        ready1, ready2;
    logic [hyp_pkg::DATA_W-1:0]  both;
    logic [hyp_pkg::LEN_W-1:0]   bit_len;

    assign ready2   = !valid2_reg || out_ready;
    assign ready1   = !valid1_reg || ready2;
    assign in_ready = ready1;

    always_comb begin
        mag_x_next = delta_x[hyp_pkg::DATA_W-1] ? (hyp_pkg::DATA_W'(0) - delta_x) : delta_x;
        mag_y_next = delta_y[hyp_pkg::DATA_W-1] ? (hyp_pkg::DATA_W'(0) - delta_y) : delta_y;
        both       = mag_x_next | mag_y_next;
        bit_len    = '0;
        for (int i = 0; i < hyp_pkg::DATA_W; i++) begin
            if (both[i]) begin
                bit_len = hyp_pkg::LEN_W'(i + 1);
            end
        end
        if (bit_len > hyp_pkg::LEN_W'(hyp_pkg::MAG_W)) begin
            shift_next = hyp_pkg::SHIFT_W'(bit_len - hyp_pkg::LEN_W'(hyp_pkg::MAG_W));
        end else begin
            shift_next = '0;
        end
    end

    always_comb begin
        scaled_next.mag_x = hyp_pkg::MAG_W'(mag_x_reg >> shift_reg);
        scaled_next.mag_y = hyp_pkg::MAG_W'(mag_y_reg >> shift_reg);
        scaled_next.shift = shift_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                valid1_reg <= in_valid;
            end
            if (ready2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            shift_reg <= shift_next;
        end
        if (ready2 && valid1_reg) begin
            scaled_reg <= scaled_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_data  = scaled_reg;

endmodule

### rtl/core/hyp_square.sv
// ----------------------------------------------------------------------------
// hyp_square: sum of squares
// Squares both scaled magnitudes in one stage and adds them in the next.
// ----------------------------------------------------------------------------
module hyp_square (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  hyp_pkg::scaled_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hyp_pkg::root_t   out_data
);

    localparam int SQ_W = 2 * hyp_pkg::MAG_W;

    logic [SQ_W-1:0]             sq_x_reg, sq_y_reg;
    logic [hyp_pkg::SHIFT_W-1:0] shift_reg;
    logic                        valid1_reg;
    hyp_pkg::root_t              sum_reg, sum_next;
    logic                        valid2_reg;
    logic                        ready1, ready2;

    assign ready2   = !valid2_reg || out_ready;
    assign ready1   = !valid1_reg || ready2;
    assign in_ready = ready1;

    always_comb begin
        sum_next.rem   = hyp_pkg::DATA_W'(sq_x_reg) + hyp_pkg::DATA_W'(sq_y_reg);
        sum_next.root  = '0;
        sum_next.shift = shift_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                valid1_reg <= in_valid;
            end
            if (ready2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            sq_x_reg  <= SQ_W'(in_data.mag_x) * SQ_W'(in_data.mag_x);
            sq_y_reg  <= SQ_W'(in_data.mag_y) * SQ_W'(in_data.mag_y);
            shift_reg <= in_data.shift;
        end
        if (ready2 && valid1_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_data  = sum_reg;

endmodule

### rtl/core/hyp_isqrt.sv
// ----------------------------------------------------------------------------
// hyp_isqrt: pipelined restoring square root
// Sixteen bit-by-bit steps, two per register stage.
// ----------------------------------------------------------------------------
module hyp_isqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hyp_pkg::root_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hyp_pkg::root_t out_data
);

    hyp_pkg::root_t                  data_reg  [hyp_pkg::ROOT_STAGES];
    logic [hyp_pkg::ROOT_STAGES-1:0] valid_reg;
    logic [hyp_pkg::ROOT_STAGES:0]   stage_ready;

    assign stage_ready[hyp_pkg::ROOT_STAGES] = out_ready;
    assign in_ready = stage_ready[0];

    for (genvar s = 0; s < hyp_pkg::ROOT_STAGES; s++) begin : g_stage
        hyp_pkg::root_t stage_in;
        hyp_pkg::root_t data_next;
        logic           stage_in_valid;

        if (s == 0) begin : g_first
            assign stage_in       = in_data;
            assign stage_in_valid = in_valid;
        end else begin : g_rest
            assign stage_in       = data_reg[s-1];
            assign stage_in_valid = valid_reg[s-1];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        always_comb begin
            data_next = stage_in;
            for (int j = 0; j < hyp_pkg::STEPS_PER_STAGE; j++) begin
                data_next = hyp_pkg::root_step(data_next, s * hyp_pkg::STEPS_PER_STAGE + j);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stage_ready[s]) begin
                valid_reg[s] <= stage_in_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[s] && stage_in_valid) begin
                data_reg[s] <= data_next;
            end
        end
    end

    assign out_valid = valid_reg[hyp_pkg::ROOT_STAGES-1];
    assign out_data  = data_reg[hyp_pkg::ROOT_STAGES-1];

endmodule

### rtl/core/hyp_rescale.sv
// ----------------------------------------------------------------------------
// hyp_rescale: rounding and shift back
// Rounds the root up when the remainder exceeds it, then undoes the prescale
// and adds half of the last dropped unit. Wraps modulo 2^32.
// ----------------------------------------------------------------------------
module hyp_rescale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  hyp_pkg::root_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hyp_pkg::DATA_W-1:0] distance
);

    logic [hyp_pkg::DATA_W-1:0]  rounded_reg, rounded_next;
    logic [hyp_pkg::SHIFT_W-1:0] shift_reg;
    logic                        valid1_reg;
    logic [hyp_pkg::DATA_W-1:0]  distance_reg, distance_next;
    logic                        valid2_reg;
    logic                        ready1, ready2;
    logic [hyp_pkg::DATA_W-1:0]  half_unit;

    assign ready2   = !valid2_reg || out_ready;
    assign ready1   = !valid1_reg || ready2;
    assign in_ready = ready1;

    assign rounded_next = (in_data.root < in_data.rem) ? (in_data.root + hyp_pkg::DATA_W'(1))
                                                       : in_data.root;

    always_comb begin
        if (shift_reg != '0) begin
            half_unit = hyp_pkg::DATA_W'(1) << (shift_reg - hyp_pkg::SHIFT_W'(1));
        end else begin
            half_unit = '0;
        end
        distance_next = (rounded_reg << shift_reg) + half_unit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                valid1_reg <= in_valid;
            end
            if (ready2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            rounded_reg <= rounded_next;
            shift_reg   <= in_data.shift;
        end
        if (ready2 && valid1_reg) begin
            distance_reg <= distance_next;
        end
    end

    assign out_valid = valid2_reg;
    assign distance  = distance_reg;

endmodule
